// File: src/dnsrap_pkg.sv
// Shared types and constants for the DNS response address parser.
package dnsrap_pkg;

	localparam int unsigned HEADER_BYTES    = 12;
	localparam int unsigned RR_HEAD_BYTES   = 12;
	localparam int unsigned QTAIL_BYTES     = 4;
	localparam int unsigned A_RECORD_TYPE   = 1;
	localparam int unsigned A_RECORD_LENGTH = 4;
	localparam int unsigned RES_FIFO_DEPTH  = 8;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_QLEN   = 3'd1,
		PH_QBODY  = 3'd2,
		PH_QTAIL  = 3'd3,
		PH_AHEAD  = 3'd4,
		PH_ADATA  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_ADDR = 2'd2
	} status_t;

	typedef enum logic {
		KIND_ADDR   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] request_id;
		logic [31:0] ipv4_address;
		logic [1:0]  packet_status;
		logic        last_result;
	} result_t;

	typedef struct packed {
		logic    addr_valid;
		logic    stat_valid;
		result_t addr_res;
		result_t stat_res;
	} res_pair_t;

endpackage

// File: src/dnsrap_if.sv
// Handshake channel interfaces for datagram bytes and parse results.
interface dnsrap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source(output valid, output data_byte, output end_of_packet, input ready);
	modport sink(input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface dnsrap_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] request_id;
	logic [31:0] ipv4_address;
	logic [1:0]  packet_status;
	logic        last_result;

	modport source(output valid, output result_kind, output request_id, output ipv4_address,
		output packet_status, output last_result, input ready);
	modport sink(input valid, input result_kind, input request_id, input ipv4_address,
		input packet_status, input last_result, output ready);
endinterface

// File: src/dns_response_address_parser.sv
// A transferred byte is registered in the input stage, which then updates the parse
// state; its results enter the result queue and are offered on the result channel.
// Throughput: one byte per cycle, as long as the eight-entry result queue drains;
// a byte may yield an address and a status result, popped one per cycle on ready.
// Reset clears the parse state, the input stage and the result queue at once,
// and parsing the final byte of each datagram returns the parser to its reset state.
module dns_response_address_parser #(
	parameter int unsigned FIFO_DEPTH = dnsrap_pkg::RES_FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	dnsrap_byte_if.sink      bytes,
	dnsrap_result_if.source  results
);

	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  eop_s1;
	dnsrap_pkg::res_pair_t pair;
	dnsrap_pkg::result_t   head;
	logic [CW-1:0]         level;
	logic [CW:0]           committed;
	logic                  pop;

	always_comb begin
		committed   = {1'b0, level} + (valid_s1 ? (CW+1)'(2) : (CW+1)'(0));
		bytes.ready = committed <= (CW+1)'(FIFO_DEPTH - 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= bytes.valid && bytes.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1 <= bytes.data_byte;
			eop_s1  <= bytes.end_of_packet;
		end
	end

	dnsrap_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1),
		.data_byte     (data_s1),
		.end_of_packet (eop_s1),
		.pair          (pair)
	);

	dnsrap_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pair),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	assign results.valid         = level != CW'(0);
	assign pop                   = results.valid && results.ready;
	assign results.result_kind   = head.result_kind;
	assign results.request_id    = head.request_id;
	assign results.ipv4_address  = head.ipv4_address;
	assign results.packet_status = head.packet_status;
	assign results.last_result   = head.last_result;

endmodule

// File: src/dnsrap_parse.sv
// Per-byte DNS response parse state and result generation.
module dnsrap_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_packet,
	output dnsrap_pkg::res_pair_t pair
);

	localparam logic [15:0] HEAD_LAST  = 16'(dnsrap_pkg::HEADER_BYTES - 1);
	localparam logic [15:0] RR_LAST    = 16'(dnsrap_pkg::RR_HEAD_BYTES - 1);
	localparam logic [15:0] QTAIL_LAST = 16'(dnsrap_pkg::QTAIL_BYTES - 1);
	localparam logic [15:0] A_TYPE     = 16'(dnsrap_pkg::A_RECORD_TYPE);
	localparam logic [15:0] A_LEN      = 16'(dnsrap_pkg::A_RECORD_LENGTH);

	dnsrap_pkg::phase_t phase_q, phase_n;
	logic [15:0] cnt_q, cnt_n;
	logic [15:0] id_q, id_n;
	logic [15:0] qleft_q, qleft_n;
	logic [15:0] aleft_q, aleft_n;
	logic [7:0]  lbl_q, lbl_n;
	logic [15:0] rtype_q, rtype_n;
	logic [15:0] rlen_q, rlen_n;
	logic [31:0] acc_q, acc_n;
	logic        seen_q, seen_n;
	logic        hit;

	function automatic dnsrap_pkg::phase_t next_section(input logic [15:0] q,
		input logic [15:0] a);
		dnsrap_pkg::phase_t p;
		if (q != 16'd0) begin
			p = dnsrap_pkg::PH_QLEN;
		end else if (a != 16'd0) begin
			p = dnsrap_pkg::PH_AHEAD;
		end else begin
			p = dnsrap_pkg::PH_DONE;
		end
		return p;
	endfunction

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		id_n    = id_q;
		qleft_n = qleft_q;
		aleft_n = aleft_q;
		lbl_n   = lbl_q;
		rtype_n = rtype_q;
		rlen_n  = rlen_q;
		acc_n   = acc_q;
		seen_n  = seen_q;
		hit     = 1'b0;
		case (phase_q)
			dnsrap_pkg::PH_HEADER: begin
				if (cnt_q inside {16'd0, 16'd1}) begin
					id_n = {id_q[7:0], data_byte};
				end else if (cnt_q inside {16'd4, 16'd5}) begin
					qleft_n = {qleft_q[7:0], data_byte};
				end else if (cnt_q inside {16'd6, 16'd7}) begin
					aleft_n = {aleft_q[7:0], data_byte};
				end
				if (cnt_q >= HEAD_LAST) begin
					cnt_n   = 16'd0;
					phase_n = next_section(qleft_n, aleft_n);
				end else begin
					cnt_n = cnt_q + 16'd1;
				end
			end
			dnsrap_pkg::PH_QLEN: begin
				if (data_byte == 8'd0) begin
					phase_n = dnsrap_pkg::PH_QTAIL;
					cnt_n   = 16'd0;
				end else begin
					lbl_n   = data_byte;
					phase_n = dnsrap_pkg::PH_QBODY;
				end
			end
			dnsrap_pkg::PH_QBODY: begin
				lbl_n = lbl_q - 8'd1;
				if (lbl_n == 8'd0) begin
					phase_n = dnsrap_pkg::PH_QLEN;
				end
			end
			dnsrap_pkg::PH_QTAIL: begin
				if (cnt_q >= QTAIL_LAST) begin
					qleft_n = qleft_q - 16'd1;
					cnt_n   = 16'd0;
					phase_n = next_section(qleft_n, aleft_q);
				end else begin
					cnt_n = cnt_q + 16'd1;
				end
			end
			dnsrap_pkg::PH_AHEAD: begin
				if (cnt_q inside {16'd2, 16'd3}) begin
					rtype_n = {rtype_q[7:0], data_byte};
				end else if (cnt_q inside {16'd10, 16'd11}) begin
					rlen_n = {rlen_q[7:0], data_byte};
				end
				if (cnt_q >= RR_LAST) begin
					acc_n = 32'd0;
					if (rlen_n == 16'd0) begin
						hit     = (rtype_n == A_TYPE) && (rlen_n == A_LEN);
						aleft_n = aleft_q - 16'd1;
						cnt_n   = 16'd0;
						phase_n = next_section(qleft_q, aleft_n);
					end else begin
						phase_n = dnsrap_pkg::PH_ADATA;
						cnt_n   = rlen_n;
					end
				end else begin
					cnt_n = cnt_q + 16'd1;
				end
			end
			dnsrap_pkg::PH_ADATA: begin
				acc_n = {acc_q[23:0], data_byte};
				cnt_n = cnt_q - 16'd1;
				if (cnt_n == 16'd0) begin
					hit     = (rtype_q == A_TYPE) && (rlen_q == A_LEN);
					aleft_n = aleft_q - 16'd1;
					phase_n = next_section(qleft_q, aleft_n);
				end
			end
			default: begin
			end
		endcase
		if (hit) begin
			seen_n = 1'b1;
		end
	end

	always_comb begin
		pair.addr_valid               = step && hit;
		pair.addr_res.result_kind     = dnsrap_pkg::KIND_ADDR;
		pair.addr_res.request_id      = id_n;
		pair.addr_res.ipv4_address    = acc_n;
		pair.addr_res.packet_status   = dnsrap_pkg::ST_FOUND;
		pair.addr_res.last_result     = !end_of_packet;
		pair.stat_valid               = step && end_of_packet;
		pair.stat_res.result_kind     = dnsrap_pkg::KIND_STATUS;
		pair.stat_res.request_id      = id_n;
		pair.stat_res.ipv4_address    = 32'd0;
		pair.stat_res.last_result     = 1'b1;
		if (phase_n != dnsrap_pkg::PH_DONE) begin
			pair.stat_res.packet_status = dnsrap_pkg::ST_INVALID;
		end else if (seen_n) begin
			pair.stat_res.packet_status = dnsrap_pkg::ST_FOUND;
		end else begin
			pair.stat_res.packet_status = dnsrap_pkg::ST_NO_ADDR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dnsrap_pkg::PH_HEADER;
			cnt_q   <= 16'd0;
			id_q    <= 16'd0;
			qleft_q <= 16'd0;
			aleft_q <= 16'd0;
			lbl_q   <= 8'd0;
			rtype_q <= 16'd0;
			rlen_q  <= 16'd0;
			acc_q   <= 32'd0;
			seen_q  <= 1'b0;
		end else if (step) begin
			if (end_of_packet) begin
				phase_q <= dnsrap_pkg::PH_HEADER;
				cnt_q   <= 16'd0;
				id_q    <= 16'd0;
				qleft_q <= 16'd0;
				aleft_q <= 16'd0;
				lbl_q   <= 8'd0;
				rtype_q <= 16'd0;
				rlen_q  <= 16'd0;
				acc_q   <= 32'd0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
				id_q    <= id_n;
				qleft_q <= qleft_n;
				aleft_q <= aleft_n;
				lbl_q   <= lbl_n;
				rtype_q <= rtype_n;
				rlen_q  <= rlen_n;
				acc_q   <= acc_n;
				seen_q  <= seen_n;
			end
		end
	end

endmodule

// File: src/dnsrap_fifo.sv
// Result queue that takes up to two results per cycle and releases one.
module dnsrap_fifo #(
	parameter int unsigned DEPTH = dnsrap_pkg::RES_FIFO_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dnsrap_pkg::res_pair_t       push,
	input  logic                        pop,
	output dnsrap_pkg::result_t         head,
	output logic [$clog2(DEPTH+1)-1:0]  level
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dnsrap_pkg::result_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] level_q;
	dnsrap_pkg::result_t first;
	logic          any_push;
	logic          both_push;
	logic [CW-1:0] push_cnt;
	logic [PW-1:0] wr_ptr_next;

	always_comb begin
		any_push    = push.addr_valid || push.stat_valid;
		both_push   = push.addr_valid && push.stat_valid;
		first       = push.addr_valid ? push.addr_res : push.stat_res;
		push_cnt    = both_push ? CW'(2) : (any_push ? CW'(1) : CW'(0));
		wr_ptr_next = wr_ptr_q + PW'(1);
	end

	always_ff @(posedge clk) begin
		if (any_push) begin
			mem[wr_ptr_q] <= first;
		end
		if (both_push) begin
			mem[wr_ptr_next] <= push.stat_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			level_q <= level_q + push_cnt - (pop ? CW'(1) : CW'(0));
		end
	end

	assign head  = mem[rd_ptr_q];
	assign level = level_q;

endmodule
